// ----- rtl/assert_macros.svh -----
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define PIP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define PIP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// ----- rtl/pip_pkg.sv -----
// shared constants and types of the point-in-polygon block
package pip_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int WC_W         = 14;
    localparam int DIFF_W       = COORD_BITS + 1;
    localparam int PROD_W       = 2 * DIFF_W;
    localparam int VTX_W        = 2 * COORD_BITS;

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [WC_W-1:0]       t_wc;

    // one edge to test against the query point
    typedef struct packed {
        logic   vld;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
        t_coord px;
        t_coord py;
    } t_edge;

    // winding contribution of one edge
    typedef struct packed {
        logic vld;
        logic inc;
        logic dec;
    } t_step;

endpackage

// ----- rtl/pip_if.sv -----
// valid/ready channel interfaces for the input and result words
interface pip_in_if import pip_pkg::*;;
    logic   valid;
    logic   ready;
    logic   opcode;
    logic   new_polygon;
    t_coord coord_x;
    t_coord coord_y;

    modport source (output valid, opcode, new_polygon, coord_x, coord_y, input ready);
    modport sink   (input valid, opcode, new_polygon, coord_x, coord_y, output ready);
endinterface

interface pip_out_if import pip_pkg::*;;
    logic valid;
    logic ready;
    logic inside_res;
    t_wc  winding_count;
    logic overflowed;

    modport source (output valid, inside_res, winding_count, overflowed, input ready);
    modport sink   (input valid, inside_res, winding_count, overflowed, output ready);
endinterface

// ----- rtl/pip_ram.sv -----
// generic single-write, single-read ram with registered read data
module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ----- rtl/pip_edge.sv -----
// three-stage edge test: crossing class, cross products, left-of-edge compare
module pip_edge import pip_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_edge i_edge,
    output t_step o_step,
    output logic  o_busy
);

    logic                     r_s1_vld;
    logic                     r_s1_up;
    logic                     r_s1_dn;
    logic signed [DIFF_W-1:0] r_s1_pxa;
    logic signed [DIFF_W-1:0] r_s1_pya;
    logic signed [DIFF_W-1:0] r_s1_dx;
    logic signed [DIFF_W-1:0] r_s1_dy;
    logic                     r_s2_vld;
    logic                     r_s2_up;
    logic                     r_s2_dn;
    logic signed [PROD_W-1:0] r_s2_p1;
    logic signed [PROD_W-1:0] r_s2_p2;
    logic                     r_s3_vld;
    logic                     r_s3_inc;
    logic                     r_s3_dec;

    logic                     n_up;
    logic                     n_dn;

    // crossing class of the edge against the horizontal line through the point
    always_comb begin
        n_up = (i_edge.ay <= i_edge.py) && (i_edge.by >  i_edge.py);
        n_dn = (i_edge.ay >  i_edge.py) && (i_edge.by <= i_edge.py);
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_edge.vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        r_s1_up  <= n_up;
        r_s1_dn  <= n_dn;
        r_s1_pxa <= DIFF_W'($signed(i_edge.px)) - DIFF_W'($signed(i_edge.ax));
        r_s1_pya <= DIFF_W'($signed(i_edge.py)) - DIFF_W'($signed(i_edge.ay));
        r_s1_dx  <= DIFF_W'($signed(i_edge.bx)) - DIFF_W'($signed(i_edge.ax));
        r_s1_dy  <= DIFF_W'($signed(i_edge.by)) - DIFF_W'($signed(i_edge.ay));
        r_s2_up  <= r_s1_up;
        r_s2_dn  <= r_s1_dn;
        r_s2_p1  <= PROD_W'(r_s1_pxa) * PROD_W'(r_s1_dy);
        r_s2_p2  <= PROD_W'(r_s1_pya) * PROD_W'(r_s1_dx);
        r_s3_inc <= r_s2_up && (r_s2_p1 < r_s2_p2);
        r_s3_dec <= r_s2_dn && (r_s2_p1 > r_s2_p2);
    end

    assign o_step = {r_s3_vld, r_s3_inc, r_s3_dec};
    assign o_busy = r_s1_vld | r_s2_vld | r_s3_vld;

endmodule

// ----- rtl/point_in_polygon_winding.sv -----
// top level of the winding-number point-in-polygon block
// Load words append one vertex each to a 64-entry vertex ram; a load with new_polygon starts a
// fresh polygon, and vertices beyond capacity are dropped and flagged. A query word walks the
// closed polygon by reading one vertex per cycle from the ram through its single read port,
// whose registered read data feeds the three-stage edge pipeline; a query on an empty polygon
// goes straight to the result, and a single vertex gives no edge.
// Input is taken only between queries; a finished result waits in the output register while
// further loads are taken, and the next query result waits for it to drain.
module point_in_polygon_winding import pip_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pip_in_if.sink       i_in,
    pip_out_if.source    o_out
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_rd_idx;
    logic               r_d_vld;
    logic               r_d_first;
    logic               r_d_last;
    logic               r_close;
    t_wc                r_wc;
    logic               r_out_valid;
    logic               r_out_inside;
    t_wc                r_out_wc;
    logic               r_out_ovf;
    logic [VTX_W-1:0]   r_v0;
    logic [VTX_W-1:0]   r_prev;
    t_coord             r_px;
    t_coord             r_py;

    logic               accept;
    logic               ld;
    logic               qry;
    logic               has_room;
    logic               ram_we;
    logic [VIDX_W-1:0]  ram_waddr;
    logic               ram_re;
    logic [VTX_W-1:0]   ram_rdata;
    logic               rd_last;
    t_edge              edge_in;
    t_step              step;
    logic               edge_busy;

    // input handshake
    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign ld         = accept && (i_in.opcode == OP_LOAD);
    assign qry        = accept && (i_in.opcode == OP_QUERY);
    assign has_room   = r_count < CNT_W'(MAX_VERTICES);

    // vertex store write side
    assign ram_we    = ld && (i_in.new_polygon || has_room);
    assign ram_waddr = i_in.new_polygon ? '0 : r_count[VIDX_W-1:0];

    // vertex store read side
    assign ram_re  = (r_state == S_WALK);
    assign rd_last = (r_rd_idx == r_count - CNT_W'(1));

    pip_ram #(
        .WIDTH (VTX_W),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_in.coord_y, i_in.coord_x}),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[VIDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // edge from the previous vertex to the arriving one, or the closing edge back to the first
    always_comb begin
        edge_in.vld = (r_d_vld && !r_d_first) || r_close;
        edge_in.ax  = r_prev[COORD_BITS-1:0];
        edge_in.ay  = r_prev[VTX_W-1:COORD_BITS];
        edge_in.bx  = r_close ? r_v0[COORD_BITS-1:0]     : ram_rdata[COORD_BITS-1:0];
        edge_in.by  = r_close ? r_v0[VTX_W-1:COORD_BITS] : ram_rdata[VTX_W-1:COORD_BITS];
        edge_in.px  = r_px;
        edge_in.py  = r_py;
    end

    pip_edge u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_in),
        .o_step  (step),
        .o_busy  (edge_busy)
    );

    // control state, vertex bookkeeping, winding count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_rd_idx    <= '0;
            r_d_vld     <= 1'b0;
            r_d_first   <= 1'b0;
            r_d_last    <= 1'b0;
            r_close     <= 1'b0;
            r_wc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_d_vld   <= ram_re;
            r_d_first <= (r_rd_idx == '0);
            r_d_last  <= rd_last;
            r_close   <= r_d_vld && r_d_last && !r_d_first;

            if (step.vld && step.inc) begin
                r_wc <= r_wc + WC_W'(1);
            end else if (step.vld && step.dec) begin
                r_wc <= r_wc - WC_W'(1);
            end

            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (ld) begin
                        if (i_in.new_polygon) begin
                            r_count <= CNT_W'(1);
                            r_ovf   <= 1'b0;
                        end else if (has_room) begin
                            r_count <= r_count + CNT_W'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    if (qry) begin
                        r_wc     <= '0;
                        r_rd_idx <= '0;
                        r_state  <= (r_count == '0) ? S_FIN : S_WALK;
                    end
                end
                S_WALK: begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                    if (rd_last) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_d_vld && !r_close && !edge_busy) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= (r_wc > 0);
                        r_out_wc     <= r_wc;
                        r_out_ovf    <= r_ovf;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // query point and walk vertices
    always_ff @(posedge i_clk) begin
        if (qry) begin
            r_px <= i_in.coord_x;
            r_py <= i_in.coord_y;
        end
        if (r_d_vld) begin
            r_prev <= ram_rdata;
            if (r_d_first) begin
                r_v0 <= ram_rdata;
            end
        end
    end

    // result word
    assign o_out.valid         = r_out_valid;
    assign o_out.inside_res    = r_out_inside;
    assign o_out.winding_count = r_out_wc;
    assign o_out.overflowed    = r_out_ovf;

endmodule

// ----- rtl/pip_checker.sv -----
// port-level checks of the point-in-polygon block and their binding
`include "assert_macros.svh"

module pip_checker import pip_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_opcode,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_inside_res,
    input t_wc  i_out_winding_count
);

    // a stalled result word stays offered
    `PIP_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)

    // inside flag agrees with the sign of the count
    `PIP_ASSERT_SAME(a_inside_sign, i_out_valid, i_out_inside_res == (i_out_winding_count > 0))

    // a load never produces a result word
    `PIP_ASSERT_NEXT(a_load_silent,
        i_in_valid && i_in_ready && (i_in_opcode == OP_LOAD) && !i_out_valid, !i_out_valid)

    // input is held off while a query is being walked
    `PIP_ASSERT_NEXT(a_query_busy,
        i_in_valid && i_in_ready && (i_in_opcode == OP_QUERY), !i_in_ready)

endmodule

bind point_in_polygon_winding pip_checker u_pip_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_in_valid          (i_in.valid),
    .i_in_ready          (i_in.ready),
    .i_in_opcode         (i_in.opcode),
    .i_out_valid         (o_out.valid),
    .i_out_ready         (o_out.ready),
    .i_out_inside_res    (o_out.inside_res),
    .i_out_winding_count (o_out.winding_count)
);

// ----- tb/tb.sv -----
// self-checking testbench of the winding-number point-in-polygon block
`timescale 1ns / 1ps

module tb import pip_pkg::*; ;

    localparam int     RANDOM_ITEMS = 440;
    localparam int     QUERY_LAT    = 80;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_LIMIT  = 20000;
    localparam t_coord COORD_MIN    = t_coord'(-(2 ** (COORD_BITS - 1)));
    localparam t_coord COORD_MAX    = t_coord'(2 ** (COORD_BITS - 1) - 1);

    // coordinate distributions for random polygons
    typedef enum int { SPAN_SMALL, SPAN_FULL, SPAN_GRID } t_coord_span;

    // receiver stall patterns
    typedef enum int { RDY_ALWAYS, RDY_MOSTLY, RDY_EVERY_THIRD, RDY_SPARSE } t_rdy_mode;

    // one expected result word
    typedef struct {
        logic in_poly;
        t_wc  wc;
        logic ovf;
    } t_poly_verdict;

    logic i_clk;
    logic i_rst_n;

    pip_in_if  in_ch ();
    pip_out_if out_ch ();

    point_in_polygon_winding dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // shadow copy of the polygon held by the block
    t_coord vtx_x [MAX_VERTICES];
    t_coord vtx_y [MAX_VERTICES];
    int     vtx_cnt;
    logic   vtx_ovf;

    t_poly_verdict pending_verdicts [$];
    int            err_cnt;
    int            items_sent;
    int            burst_left;
    int            hold_request;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // winding count of a point against the shadow polygon
    function automatic t_poly_verdict winding_verdict(t_coord qx, t_coord qy);
        t_poly_verdict v;
        int            wc;
        int            j;
        longint        ax, ay, bx, by, px, py, lhs, rhs;
        wc = 0;
        px = qx;
        py = qy;
        for (int i = 0; i < vtx_cnt; i++) begin
            j   = (i + 1 < vtx_cnt) ? i + 1 : 0;
            ax  = vtx_x[i];
            ay  = vtx_y[i];
            bx  = vtx_x[j];
            by  = vtx_y[j];
            lhs = (px - ax) * (by - ay);
            rhs = (py - ay) * (bx - ax);
            if (ay <= py && by > py) begin
                if (lhs < rhs) wc++;
            end else if (ay > py && by <= py) begin
                if (lhs > rhs) wc--;
            end
        end
        v.in_poly = (wc > 0);
        v.wc      = t_wc'(wc);
        v.ovf     = vtx_ovf;
        return v;
    endfunction

    // update the shadow polygon with one accepted word
    function automatic void track_word(logic op, logic np, t_coord x, t_coord y);
        if (op == OP_LOAD) begin
            if (np) begin
                vtx_cnt = 0;
                vtx_ovf = 1'b0;
            end
            if (vtx_cnt < MAX_VERTICES) begin
                vtx_x[vtx_cnt] = x;
                vtx_y[vtx_cnt] = y;
                vtx_cnt++;
            end else begin
                vtx_ovf = 1'b1;
            end
        end else begin
            pending_verdicts.insert(pending_verdicts.size(), winding_verdict(x, y));
        end
    endfunction

    function automatic t_coord rand_coord(t_coord_span span);
        case (span)
            SPAN_SMALL: return t_coord'(int'($urandom_range(0, 400)) - 200);
            SPAN_GRID:  return t_coord'((int'($urandom_range(0, 16)) - 8) * 16);
            default:    return t_coord'($urandom());
        endcase
    endfunction

    function automatic t_coord_span pick_span();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return SPAN_SMALL;
        if (r < 9) return SPAN_FULL;
        return SPAN_GRID;
    endfunction

    // offer one word in bursts with random gaps, wait for the handshake
    task automatic send_word(input logic op, input logic np, input t_coord x, input t_coord y);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.new_polygon <= np;
        in_ch.coord_x     <= x;
        in_ch.coord_y     <= y;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_word(op, np, x, y);
        items_sent++;
        burst_left--;
    endtask

    // result checker and receiver stall pattern
    initial begin
        t_rdy_mode     mode;
        int            mode_left;
        int            phase;
        int            stall_left;
        logic          nr;
        t_poly_verdict exp_v;
        mode         = RDY_ALWAYS;
        mode_left    = 0;
        phase        = 0;
        stall_left   = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready) begin
                if (pending_verdicts.size() == 0) begin
                    $display("%0t: result word with none expected: inside %0d count %0d ovf %0d",
                             $time, out_ch.inside_res, out_ch.winding_count,
                             out_ch.overflowed);
                    err_cnt++;
                end else begin
                    exp_v = pending_verdicts.pop_front();
                    if (out_ch.inside_res !== exp_v.in_poly) begin
                        $display("%0t: inside_res expected %0d actual %0d",
                                 $time, exp_v.in_poly, out_ch.inside_res);
                        err_cnt++;
                    end
                    if (out_ch.winding_count !== exp_v.wc) begin
                        $display("%0t: winding_count expected %0d actual %0d",
                                 $time, exp_v.wc, out_ch.winding_count);
                        err_cnt++;
                    end
                    if (out_ch.overflowed !== exp_v.ovf) begin
                        $display("%0t: overflowed expected %0d actual %0d",
                                 $time, exp_v.ovf, out_ch.overflowed);
                        err_cnt++;
                    end
                end
            end
            // long hold-off requested by a test
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                mode      = t_rdy_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            phase++;
            case (mode)
                RDY_ALWAYS:      nr = 1'b1;
                RDY_MOSTLY:      nr = ($urandom_range(0, 9) < 7);
                RDY_EVERY_THIRD: nr = (phase % 3 == 0);
                default:         nr = ($urandom_range(0, 9) < 3);
            endcase
            if (stall_left > 0) begin
                nr = 1'b0;
                stall_left--;
            end
            out_ch.ready <= nr;
        end
    end

    // empty store, then a single degenerate vertex
    task automatic test_empty_and_single();
        send_word(OP_QUERY, 1'b1, 16'sd0, 16'sd0);
        send_word(OP_LOAD, 1'b1, 16'sd16, 16'sd16);
        send_word(OP_QUERY, 1'b0, 16'sd16, 16'sd16);
    endtask

    // counter-clockwise square: inside, outside, on an edge, on a vertex
    task automatic test_unit_square();
        send_word(OP_LOAD, 1'b1, 16'sd0, 16'sd0);
        send_word(OP_LOAD, 1'b0, 16'sd160, 16'sd0);
        send_word(OP_LOAD, 1'b0, 16'sd160, 16'sd160);
        send_word(OP_LOAD, 1'b0, 16'sd0, 16'sd160);
        send_word(OP_QUERY, 1'b0, 16'sd80, 16'sd80);
        send_word(OP_QUERY, 1'b1, 16'sd200, 16'sd80);
        send_word(OP_QUERY, 1'b0, 16'sd0, 16'sd80);
        send_word(OP_QUERY, 1'b0, 16'sd0, 16'sd0);
    endtask

    // triangle walked twice gives a count of two
    task automatic test_double_wind();
        repeat (2) begin
            send_word(OP_LOAD, (vtx_cnt == 3) ? 1'b0 : 1'b1, 16'sd0, 16'sd0);
            send_word(OP_LOAD, 1'b0, 16'sd320, 16'sd0);
            send_word(OP_LOAD, 1'b0, 16'sd0, 16'sd320);
        end
        send_word(OP_QUERY, 1'b0, 16'sd32, 16'sd32);
    endtask

    // clockwise square on the coordinate extremes gives a negative count
    task automatic test_extremes();
        send_word(OP_LOAD, 1'b1, COORD_MIN, COORD_MIN);
        send_word(OP_LOAD, 1'b0, COORD_MIN, COORD_MAX);
        send_word(OP_LOAD, 1'b0, COORD_MAX, COORD_MAX);
        send_word(OP_LOAD, 1'b0, COORD_MAX, COORD_MIN);
        send_word(OP_QUERY, 1'b0, 16'sd0, 16'sd0);
        send_word(OP_QUERY, 1'b0, COORD_MAX, 16'sd0);
        send_word(OP_QUERY, 1'b0, COORD_MIN, COORD_MIN);
    endtask

    // fill the store, drop vertices, then clear with a new polygon
    task automatic test_overflow();
        send_word(OP_LOAD, 1'b1, rand_coord(SPAN_SMALL), rand_coord(SPAN_SMALL));
        repeat (MAX_VERTICES - 1)
            send_word(OP_LOAD, 1'b0, rand_coord(SPAN_SMALL), rand_coord(SPAN_SMALL));
        send_word(OP_QUERY, 1'b0, rand_coord(SPAN_SMALL), rand_coord(SPAN_SMALL));
        repeat (2)
            send_word(OP_LOAD, 1'b0, rand_coord(SPAN_SMALL), rand_coord(SPAN_SMALL));
        send_word(OP_QUERY, 1'b0, rand_coord(SPAN_SMALL), rand_coord(SPAN_SMALL));
        send_word(OP_LOAD, 1'b1, -16'sd160, -16'sd160);
        send_word(OP_LOAD, 1'b0, 16'sd160, -16'sd160);
        send_word(OP_LOAD, 1'b0, 16'sd0, 16'sd160);
        send_word(OP_QUERY, 1'b0, 16'sd0, 16'sd0);
    endtask

    // receiver holds off while queries keep coming
    task automatic test_backpressure();
        send_word(OP_LOAD, 1'b1, -16'sd160, -16'sd160);
        send_word(OP_LOAD, 1'b0, 16'sd160, -16'sd160);
        send_word(OP_LOAD, 1'b0, 16'sd0, 16'sd160);
        hold_request = HOLD_CYCLES;
        repeat (8) send_word(OP_QUERY, 1'b0, rand_coord(SPAN_SMALL), rand_coord(SPAN_SMALL));
    endtask

    // random polygons with several queries each, plus appended vertices
    task automatic test_random_polygons();
        int          start;
        int          nv;
        int          nq;
        int          pick;
        int          idx;
        t_coord_span span;
        t_coord      qx;
        t_coord      qy;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            span = pick_span();
            pick = $urandom_range(0, 99);
            if (pick < 3)       nv = $urandom_range(MAX_VERTICES + 1, MAX_VERTICES + 6);
            else if (pick < 8)  nv = $urandom_range(40, MAX_VERTICES);
            else if (pick < 12) nv = $urandom_range(1, 2);
            else                nv = $urandom_range(3, 12);
            for (int v = 0; v < nv; v++)
                send_word(OP_LOAD, (v == 0), rand_coord(span), rand_coord(span));
            nq = $urandom_range(1, 5);
            for (int q = 0; q < nq; q++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // exactly on a stored vertex
                    idx = $urandom_range(0, vtx_cnt - 1);
                    qx  = vtx_x[idx];
                    qy  = vtx_y[idx];
                end else begin
                    qx = rand_coord(span);
                    qy = rand_coord(span);
                end
                send_word(OP_QUERY, 1'($urandom_range(0, 1)), qx, qy);
            end
            // extend the current polygon without starting over
            if ($urandom_range(0, 7) == 0) begin
                send_word(OP_LOAD, 1'b0, rand_coord(span), rand_coord(span));
                send_word(OP_QUERY, 1'($urandom_range(0, 1)), rand_coord(span),
                          rand_coord(span));
            end
        end
    endtask

    // main sequence
    initial begin
        int drain_cycles;
        err_cnt      = 0;
        items_sent   = 0;
        burst_left   = 0;
        hold_request = 0;
        vtx_cnt      = 0;
        vtx_ovf      = 1'b0;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.opcode      <= OP_LOAD;
        in_ch.new_polygon <= 1'b0;
        in_ch.coord_x     <= '0;
        in_ch.coord_y     <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_and_single();
        test_unit_square();
        test_double_wind();
        test_extremes();
        test_overflow();
        test_backpressure();
        test_random_polygons();
        in_ch.valid <= 1'b0;

        // drain outstanding results
        drain_cycles = 0;
        while (pending_verdicts.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        if (pending_verdicts.size() != 0) begin
            $display("%0t: %0d result words never arrived", $time, pending_verdicts.size());
            err_cnt++;
        end
        repeat (QUERY_LAT) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
